// ----- rtl/core/tgu_pkg.sv -----
// Shared constants, register indexes and types of the trilinear grid upsampler.
package tgu_pkg;

  // Default sizing of the block.
  localparam int COARSE_DIM_MAX_DEF = 32;
  localparam int FINE_DIM_MAX_DEF   = 256;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int FRAC_BITS_DEF      = 16;

  // Fixed field widths of the channels.
  localparam int MODE_BITS   = 1;
  localparam int CADDR_BITS  = 15;
  localparam int CVAL_BITS   = 24;
  localparam int FVAL_BITS   = 24;
  localparam int FIDX_BITS   = 24;
  localparam int STATUS_BITS = 2;
  localparam int FSIZE_BITS  = 9;
  localparam int CSIZE_BITS  = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 9;

  // Register reset values.
  localparam logic [FSIZE_BITS-1:0] FSIZE_RESET = FSIZE_BITS'(2);
  localparam logic [CSIZE_BITS-1:0] CSIZE_RESET = CSIZE_BITS'(2);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FINE_SIZE_X   = 3'd0,
    REG_FINE_SIZE_Y   = 3'd1,
    REG_FINE_SIZE_Z   = 3'd2,
    REG_COARSE_SIZE_X = 3'd3,
    REG_COARSE_SIZE_Y = 3'd4,
    REG_COARSE_SIZE_Z = 3'd5,
    REG_BOUNDS_OK     = 3'd6
  } reg_idx_t;

  // Input word modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_LOW_RES = 2'd2
  } status_t;

endpackage

// ----- rtl/core/tgu_in_if.sv -----
// Input channel: load and step words.
interface tgu_in_if;
  logic                         valid;
  logic                         ready;
  logic [tgu_pkg::MODE_BITS-1:0]  mode;
  logic [tgu_pkg::CADDR_BITS-1:0] coarse_addr;
  logic signed [tgu_pkg::CVAL_BITS-1:0] coarse_value;

  modport source (output valid, mode, coarse_addr, coarse_value, input ready);
  modport sink   (input valid, mode, coarse_addr, coarse_value, output ready);
endinterface

// ----- rtl/core/tgu_out_if.sv -----
// Output channel: interpolated fine samples.
interface tgu_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [tgu_pkg::FVAL_BITS-1:0] fine_value;
  logic [tgu_pkg::FIDX_BITS-1:0]   fine_index;
  logic                            last_of_grid;
  logic [tgu_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, fine_value, fine_index, last_of_grid, status, input ready);
  modport sink   (input valid, fine_value, fine_index, last_of_grid, status, output ready);
endinterface

// ----- rtl/core/tgu_cfg_if.sv -----
// Configuration write channel.
interface tgu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tgu_pkg::CFG_IDX_BITS-1:0]  index;
  logic [tgu_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tgu_ram.sv -----
// Generic single-port RAM with registered read data.
module tgu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/tgu_div.sv -----
// Per-axis setup: corner indices and fraction by bit-serial restoring division.
module tgu_div #(
  parameter int PB = 8,
  parameter int CB = 5,
  parameter int F  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PB-1:0] pos,
  input  logic [PB-1:0] d,
  input  logic [CB-1:0] cs_m1,
  output logic          done,
  output logic [CB-1:0] lo,
  output logic [CB-1:0] hi,
  output logic [F-1:0]  frac
);

  localparam int NB = PB + CB;
  localparam int DW = NB + F;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [PB-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [PB:0]   trial;
  logic          ge;
  logic [NB-1:0] num;
  logic [NB-1:0] i0;

  assign num   = NB'(pos) * NB'(cs_m1);
  assign trial = {rem, dvd[DW-1]};
  assign ge    = trial >= {1'b0, d};

  // The quotient of (num << F) / d holds the index over the fraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        rem  <= '0;
        dvd  <= DW'(num) << F;
      end else if (busy) begin
        rem <= ge ? PB'(trial - {1'b0, d}) : PB'(trial);
        dvd <= {dvd[DW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Clamp the lower corner and derive the upper one.
  assign i0   = dvd[DW-1:F];
  assign lo   = (i0 > NB'(cs_m1)) ? cs_m1 : CB'(i0);
  assign hi   = (lo < cs_m1) ? lo + CB'(1) : cs_m1;
  assign frac = dvd[F-1:0];

endmodule

// ----- rtl/core/tgu_blend.sv -----
// Two-stage linear blend: a*(1-f) + b*f, rounded half up.
module tgu_blend #(
  parameter int S = 24,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [S-1:0] a,
  input  logic signed [S-1:0] b,
  input  logic [F-1:0]        f,
  output logic                done,
  output logic signed [S-1:0] y
);

  localparam int T = S + F + 2;
  localparam logic signed [T-1:0] HALF = T'(1) <<< (F - 1);

  logic signed [S:0]   diff;
  logic signed [F:0]   fs;
  logic signed [T-1:0] prod;
  logic signed [S-1:0] a_q;
  logic                s1_valid;
  logic signed [T-1:0] t;

  assign diff = $signed({b[S-1], b}) - $signed({a[S-1], a});
  assign fs   = $signed({1'b0, f});
  assign t    = (T'(a_q) <<< F) + prod + HALF;

  // Stage one multiplies the difference, stage two adds and shifts.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      done     <= s1_valid;
    end
    if (start) begin
      prod <= T'(diff * fs);
      a_q  <= a;
    end
    if (s1_valid) begin
      y <= S'(t >>> F);
    end
  end

endmodule

// ----- rtl/core/trilinear_grid_upsampler_top.sv -----
// Top level of the trilinear grid upsampler: registers, sequencer and datapath.
//
//  channel | role   | word
//  items   | sink   | mode, coarse_addr, coarse_value
//  results | source | fine_value, fine_index, last_of_grid, status
//  cfg     | sink   | index, data
//
// A load word writes the coarse store directly. A step word runs the bit-serial
// division of each axis, the multiply states MUL1 and MUL2, eight corner reads
// from the single store port, seven blends and the result state FINISH. A step
// with an error status skips the division, the corner reads and the blends.
// Reset is synchronous and clears control state only; the coarse store is not
// cleared. A stalled result holds in the output register while load words keep
// flowing; a step then waits at its end.
module trilinear_grid_upsampler_top #(
  parameter int COARSE_DIM_MAX = tgu_pkg::COARSE_DIM_MAX_DEF,
  parameter int FINE_DIM_MAX   = tgu_pkg::FINE_DIM_MAX_DEF,
  parameter int SAMPLE_BITS    = tgu_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS      = tgu_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  tgu_in_if.sink   items,
  tgu_out_if.source results,
  tgu_cfg_if.sink  cfg
);

  localparam int PB    = $clog2(FINE_DIM_MAX);
  localparam int FSW   = $clog2(FINE_DIM_MAX + 1);
  localparam int CB    = $clog2(COARSE_DIM_MAX);
  localparam int CSW   = $clog2(COARSE_DIM_MAX + 1);
  localparam int DEPTH = COARSE_DIM_MAX * COARSE_DIM_MAX * COARSE_DIM_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = 3 * FSW;
  localparam int OW    = (IW > tgu_pkg::FIDX_BITS) ? IW : tgu_pkg::FIDX_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam longint SMAX = (longint'(1) <<< (S - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef enum logic [6:0] {
    IDLE   = 7'b0000001,
    DIV    = 7'b0000010,
    MUL1   = 7'b0000100,
    MUL2   = 7'b0001000,
    READ   = 7'b0010000,
    BLEND  = 7'b0100000,
    FINISH = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [tgu_pkg::FSIZE_BITS-1:0] fine_size_x, fine_size_y, fine_size_z;
  logic [tgu_pkg::CSIZE_BITS-1:0] coarse_size_x, coarse_size_y, coarse_size_z;
  logic                           bounds_ok;

  // Walk position and per-step working registers.
  logic [PB-1:0]   pos_x, pos_y, pos_z;
  logic [1:0]      status;
  logic [AW-1:0]   zc [2];
  logic [AW-1:0]   row [4];
  logic [IW-1:0]   fzi, fidx;
  logic [3:0]      rd_cnt;
  logic            rd_pend;
  logic [2:0]      rd_slot;
  logic signed [S-1:0] q [8];
  logic [2:0]      bl_cnt;
  logic            bl_busy;
  logic signed [S-1:0] res_value;

  // Saturated sizes.
  logic [FSW-1:0] fx, fy, fz;
  logic [CSW-1:0] cx, cy, cz;
  logic           low_res;

  assign fx = (32'(fine_size_x) > FINE_DIM_MAX) ? FSW'(FINE_DIM_MAX) : FSW'(fine_size_x);
  assign fy = (32'(fine_size_y) > FINE_DIM_MAX) ? FSW'(FINE_DIM_MAX) : FSW'(fine_size_y);
  assign fz = (32'(fine_size_z) > FINE_DIM_MAX) ? FSW'(FINE_DIM_MAX) : FSW'(fine_size_z);
  assign cx = (32'(coarse_size_x) > COARSE_DIM_MAX) ? CSW'(COARSE_DIM_MAX)
                                                   : CSW'(coarse_size_x);
  assign cy = (32'(coarse_size_y) > COARSE_DIM_MAX) ? CSW'(COARSE_DIM_MAX)
                                                   : CSW'(coarse_size_y);
  assign cz = (32'(coarse_size_z) > COARSE_DIM_MAX) ? CSW'(COARSE_DIM_MAX)
                                                   : CSW'(coarse_size_z);
  assign low_res = (fx < FSW'(2)) || (fy < FSW'(2)) || (fz < FSW'(2)) ||
                   (cx < CSW'(2)) || (cy < CSW'(2)) || (cz < CSW'(2));

  // Per-axis dividers.
  logic          div_start;
  logic          dx_done, dy_done, dz_done;
  logic [CB-1:0] x0, x1, y0, y1, z0, z1;
  logic [F-1:0]  tx, ty, tz;

  tgu_div #(.PB(PB), .CB(CB), .F(F)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .pos(pos_x),
    .d(PB'(fx - FSW'(1))), .cs_m1(CB'(cx - CSW'(1))),
    .done(dx_done), .lo(x0), .hi(x1), .frac(tx)
  );
  tgu_div #(.PB(PB), .CB(CB), .F(F)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .pos(pos_y),
    .d(PB'(fy - FSW'(1))), .cs_m1(CB'(cy - CSW'(1))),
    .done(dy_done), .lo(y0), .hi(y1), .frac(ty)
  );
  tgu_div #(.PB(PB), .CB(CB), .F(F)) u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .pos(pos_z),
    .d(PB'(fz - FSW'(1))), .cs_m1(CB'(cz - CSW'(1))),
    .done(dz_done), .lo(z0), .hi(z1), .frac(tz)
  );

  // Shared blend unit working from the head of the corner queue.
  logic                bl_start;
  logic                bl_done;
  logic signed [S-1:0] bl_y;
  logic [F-1:0]        bl_f;

  assign bl_f = (bl_cnt < 3'd4) ? tx : ((bl_cnt < 3'd6) ? ty : tz);

  tgu_blend #(.S(S), .F(F)) u_blend (
    .clk(clk), .rst(rst), .start(bl_start), .a(q[0]), .b(q[1]),
    .f(bl_f), .done(bl_done), .y(bl_y)
  );

  // Coarse store port: loads write in idle, corner reads in the read phase.
  logic            in_acc;
  logic            load_we;
  logic [AW-1:0]   ram_addr;
  logic [AW-1:0]   rd_addr;
  logic [S-1:0]    ram_rdata;
  logic [S-1:0]    load_value;
  longint          cv64;

  assign items.ready = (state == IDLE);
  assign in_acc  = items.valid && items.ready;
  assign load_we = in_acc && (items.mode == tgu_pkg::MODE_LOAD) &&
                   (32'(items.coarse_addr) < DEPTH);
  assign cv64    = longint'(items.coarse_value);
  assign load_value = (cv64 > SMAX) ? S'(SMAX) : ((cv64 < SMIN) ? S'(SMIN) : S'(cv64));
  assign rd_addr = AW'(rd_cnt[0] ? x1 : x0) + row[rd_cnt[2:1]];
  assign ram_addr = (state == IDLE) ? AW'(items.coarse_addr) : rd_addr;

  tgu_ram #(.WIDTH(S), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(load_we), .addr(ram_addr), .wdata(load_value), .rdata(ram_rdata)
  );

  // Output register and end-of-step bookkeeping.
  logic out_free;
  logic step_ok;
  logic last_x, last_y, last_z;
  logic [OW-1:0] idx_full;

  assign out_free  = !results.valid || results.ready;
  assign step_ok   = (status == tgu_pkg::ST_OK);
  assign last_x    = (FSW'(pos_x) + FSW'(1)) >= fx;
  assign last_y    = (FSW'(pos_y) + FSW'(1)) >= fy;
  assign last_z    = (FSW'(pos_z) + FSW'(1)) >= fz;
  assign idx_full  = OW'(IW'(pos_x) + fidx);
  assign div_start = in_acc && (items.mode == tgu_pkg::MODE_STEP) &&
                     bounds_ok && !low_res;
  assign bl_start  = (state == BLEND) && !bl_busy;
  assign cfg.ready = 1'b1;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      fine_size_x   <= tgu_pkg::FSIZE_RESET;
      fine_size_y   <= tgu_pkg::FSIZE_RESET;
      fine_size_z   <= tgu_pkg::FSIZE_RESET;
      coarse_size_x <= tgu_pkg::CSIZE_RESET;
      coarse_size_y <= tgu_pkg::CSIZE_RESET;
      coarse_size_z <= tgu_pkg::CSIZE_RESET;
      bounds_ok     <= 1'b1;
      pos_x         <= '0;
      pos_y         <= '0;
      pos_z         <= '0;
      results.valid <= 1'b0;
      rd_pend       <= 1'b0;
      bl_busy       <= 1'b0;
    end else begin
      // A taken word leaves unless the finish phase loads the next one.
      if (results.valid && results.ready && (state != FINISH)) begin
        results.valid <= 1'b0;
      end

      // Register writes; a size write restarts the walk.
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          tgu_pkg::REG_FINE_SIZE_X: fine_size_x <= cfg.data;
          tgu_pkg::REG_FINE_SIZE_Y: fine_size_y <= cfg.data;
          tgu_pkg::REG_FINE_SIZE_Z: fine_size_z <= cfg.data;
          tgu_pkg::REG_COARSE_SIZE_X: coarse_size_x <= tgu_pkg::CSIZE_BITS'(cfg.data);
          tgu_pkg::REG_COARSE_SIZE_Y: coarse_size_y <= tgu_pkg::CSIZE_BITS'(cfg.data);
          tgu_pkg::REG_COARSE_SIZE_Z: coarse_size_z <= tgu_pkg::CSIZE_BITS'(cfg.data);
          tgu_pkg::REG_BOUNDS_OK: bounds_ok <= cfg.data[0];
          default: ;
        endcase
        if (cfg.index inside {tgu_pkg::REG_FINE_SIZE_X, tgu_pkg::REG_FINE_SIZE_Y,
                              tgu_pkg::REG_FINE_SIZE_Z, tgu_pkg::REG_COARSE_SIZE_X,
                              tgu_pkg::REG_COARSE_SIZE_Y, tgu_pkg::REG_COARSE_SIZE_Z}) begin
          pos_x <= '0;
          pos_y <= '0;
          pos_z <= '0;
        end
      end

      // Capture corner data in the cycle after each read.
      rd_pend <= (state == READ) && (rd_cnt < 4'd8);
      if (rd_pend) begin
        q[rd_slot] <= ram_rdata;
      end

      unique case (state)
        IDLE: begin
          if (in_acc && (items.mode == tgu_pkg::MODE_STEP)) begin
            if (!bounds_ok) begin
              status <= tgu_pkg::ST_BOUNDS;
              state  <= MUL1;
            end else if (low_res) begin
              status <= tgu_pkg::ST_LOW_RES;
              state  <= MUL1;
            end else begin
              status <= tgu_pkg::ST_OK;
              state  <= DIV;
            end
          end
        end
        DIV: begin
          if (dx_done && dy_done && dz_done) begin
            state <= MUL1;
          end
        end
        MUL1: begin
          zc[0] <= AW'(cy) * AW'(z0);
          zc[1] <= AW'(cy) * AW'(z1);
          fzi   <= IW'(fy) * IW'(pos_z);
          state <= MUL2;
        end
        MUL2: begin
          row[0] <= AW'(cx) * (AW'(y0) + zc[0]);
          row[1] <= AW'(cx) * (AW'(y1) + zc[0]);
          row[2] <= AW'(cx) * (AW'(y0) + zc[1]);
          row[3] <= AW'(cx) * (AW'(y1) + zc[1]);
          fidx   <= IW'(fx) * (IW'(pos_y) + fzi);
          rd_cnt <= '0;
          state  <= step_ok ? READ : FINISH;
        end
        READ: begin
          if (rd_cnt < 4'd8) begin
            rd_slot <= rd_cnt[2:0];
            rd_cnt  <= rd_cnt + 4'd1;
          end else begin
            bl_cnt <= '0;
            state  <= BLEND;
          end
        end
        BLEND: begin
          // Pop two operands, push the blended value behind the rest.
          if (!bl_busy) begin
            bl_busy <= 1'b1;
            for (int i = 0; i < 6; i++) begin
              q[i] <= q[i + 2];
            end
          end else if (bl_done) begin
            bl_busy <= 1'b0;
            q[3'd6 - bl_cnt] <= bl_y;
            bl_cnt <= bl_cnt + 3'd1;
            if (bl_cnt == 3'd6) begin
              res_value <= bl_y;
              state     <= FINISH;
            end
          end
        end
        FINISH: begin
          if (out_free) begin
            results.valid        <= 1'b1;
            results.fine_value   <= step_ok ? tgu_pkg::FVAL_BITS'(longint'(res_value)) : '0;
            results.fine_index   <= idx_full[tgu_pkg::FIDX_BITS-1:0];
            results.last_of_grid <= step_ok && last_x && last_y && last_z;
            results.status       <= status;
            if (step_ok) begin
              if (!last_x) begin
                pos_x <= pos_x + PB'(1);
              end else begin
                pos_x <= '0;
                if (!last_y) begin
                  pos_y <= pos_y + PB'(1);
                end else begin
                  pos_y <= '0;
                  pos_z <= last_z ? '0 : pos_z + PB'(1);
                end
              end
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- sim/trilinear_grid_upsampler_top_test.sv -----
// Self-checking testbench of the trilinear grid upsampler: loads, fine-grid walks and checks.
`timescale 1ns / 100ps

module trilinear_grid_upsampler_top_test;
  import tgu_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int STORE_WORDS = COARSE_DIM_MAX_DEF * COARSE_DIM_MAX_DEF * COARSE_DIM_MAX_DEF;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [FVAL_BITS-1:0] value;
    logic [FIDX_BITS-1:0] index;
    logic                 last;
    status_t              st;
  } fine_word_t;

  // Mirror of the upsampler state plus the queue of fine samples still owed.
  class upsample_scoreboard;
    int unsigned fine_sz[3];
    int unsigned coarse_sz[3];
    bit bounds_on;
    int unsigned pos[3];
    longint grid[STORE_WORDS];
    fine_word_t owed[$];
    int errors;
    int results_seen;
    int status_seen[3];

    function void reset_state();
      foreach (fine_sz[i]) begin
        fine_sz[i] = 2;
        coarse_sz[i] = 2;
        pos[i] = 0;
      end
      bounds_on = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FINE_SIZE_X: fine_sz[0] = data;
        REG_FINE_SIZE_Y: fine_sz[1] = data;
        REG_FINE_SIZE_Z: fine_sz[2] = data;
        REG_COARSE_SIZE_X: coarse_sz[0] = data[CSIZE_BITS-1:0];
        REG_COARSE_SIZE_Y: coarse_sz[1] = data[CSIZE_BITS-1:0];
        REG_COARSE_SIZE_Z: coarse_sz[2] = data[CSIZE_BITS-1:0];
        REG_BOUNDS_OK: begin
          bounds_on = data[0];
          return;
        end
        default: return;
      endcase
      foreach (pos[i]) pos[i] = 0;
    endfunction

    function longint blend(longint a, longint b, longint f);
      // Arithmetic shift of the rounded sum floors toward minus infinity.
      return (a * ((64'sd1 <<< FRAC_BITS_DEF) - f) + b * f
              + (64'sd1 <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
    endfunction

    function void axis(int unsigned p, int unsigned fs, int unsigned cs,
                       output int unsigned lo, output int unsigned hi, output longint fr);
      longint unsigned d, num, i0, rem;
      d = fs - 1;
      num = longint'(p) * (cs - 1);
      i0 = num / d;
      rem = num % d;
      if (i0 > cs - 1) i0 = cs - 1;
      lo = 32'(i0);
      hi = (i0 + 1 < cs) ? 32'(i0 + 1) : cs - 1;
      fr = longint'((rem << FRAC_BITS_DEF) / d);
    endfunction

    function longint corner(int unsigned x, int unsigned y, int unsigned z,
                            int unsigned sx, int unsigned sy);
      return grid[x + sx * (y + sy * z)];
    endfunction

    // Notes one accepted input word and predicts what it causes.
    function void note_item(logic m, logic [CADDR_BITS-1:0] addr, logic [CVAL_BITS-1:0] val);
      int unsigned f[3], c[3], lo[3], hi[3];
      longint t[3], c00, c10, c01, c11, c0, c1, v;
      fine_word_t w;
      if (m == MODE_LOAD) begin
        grid[addr] = longint'($signed(val));
        return;
      end
      foreach (f[i]) begin
        f[i] = fine_sz[i] > FINE_DIM_MAX_DEF ? FINE_DIM_MAX_DEF : fine_sz[i];
        c[i] = coarse_sz[i] > COARSE_DIM_MAX_DEF ? COARSE_DIM_MAX_DEF : coarse_sz[i];
      end
      w.index = FIDX_BITS'(pos[0] + f[0] * (pos[1] + f[1] * pos[2]));
      w.value = '0;
      w.last = 1'b0;
      if (!bounds_on) begin
        w.st = ST_BOUNDS;
      end else if (f[0] < 2 || f[1] < 2 || f[2] < 2 || c[0] < 2 || c[1] < 2 || c[2] < 2) begin
        w.st = ST_LOW_RES;
      end else begin
        w.st = ST_OK;
        foreach (f[i]) axis(pos[i], f[i], c[i], lo[i], hi[i], t[i]);
        c00 = blend(corner(lo[0], lo[1], lo[2], c[0], c[1]),
                    corner(hi[0], lo[1], lo[2], c[0], c[1]), t[0]);
        c10 = blend(corner(lo[0], hi[1], lo[2], c[0], c[1]),
                    corner(hi[0], hi[1], lo[2], c[0], c[1]), t[0]);
        c01 = blend(corner(lo[0], lo[1], hi[2], c[0], c[1]),
                    corner(hi[0], lo[1], hi[2], c[0], c[1]), t[0]);
        c11 = blend(corner(lo[0], hi[1], hi[2], c[0], c[1]),
                    corner(hi[0], hi[1], hi[2], c[0], c[1]), t[0]);
        c0 = blend(c00, c10, t[1]);
        c1 = blend(c01, c11, t[1]);
        v = blend(c0, c1, t[2]);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        w.value = v[FVAL_BITS-1:0];
        w.last = (pos[0] + 1 >= f[0]) && (pos[1] + 1 >= f[1]) && (pos[2] + 1 >= f[2]);
        // Raster walk with x fastest, wrapping after the last sample.
        if (pos[0] + 1 < f[0]) begin
          pos[0]++;
        end else begin
          pos[0] = 0;
          if (pos[1] + 1 < f[1]) begin
            pos[1]++;
          end else begin
            pos[1] = 0;
            pos[2] = (pos[2] + 1 < f[2]) ? pos[2] + 1 : 0;
          end
        end
      end
      owed.push_back(w);
    endfunction

    // Compares one delivered fine sample with the oldest one owed.
    function void check_result(logic [FVAL_BITS-1:0] value, logic [FIDX_BITS-1:0] index,
                               logic last, logic [STATUS_BITS-1:0] st);
      fine_word_t w;
      results_seen++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result value=%h index=%0d last=%b status=%0d",
                 $time, value, index, last, st);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (st <= ST_LOW_RES) status_seen[st]++;
      if (value !== w.value) begin
        $display("%0t: fine_value expected %h actual %h (index %0d)", $time, w.value, value,
                 w.index);
        errors++;
      end
      if (index !== w.index) begin
        $display("%0t: fine_index expected %0d actual %0d", $time, w.index, index);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_of_grid expected %b actual %b (index %0d)", $time, w.last, last,
                 w.index);
        errors++;
      end
      if (st !== w.st) begin
        $display("%0t: status expected %0d actual %0d (index %0d)", $time, w.st, st, w.index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tgu_in_if  in_ch();
  tgu_out_if out_ch();
  tgu_cfg_if cfg_ch();

  trilinear_grid_upsampler_top dut (
    .clk(clk),
    .rst(rst),
    .items(in_ch.sink),
    .results(out_ch.source),
    .cfg(cfg_ch.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  upsample_scoreboard model = new();
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_req;
  int hold_left;
  int words_sent;
  int steps_sent;
  int reg_writes;

  // Result side: check accepted words, then choose ready for the next edge.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        model.check_result(out_ch.fine_value, out_ch.fine_index, out_ch.last_of_grid,
                           out_ch.status);
      if (hold_req && hold_left == 0) begin
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= (hold_left == 1);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic m, logic [CADDR_BITS-1:0] addr, logic [CVAL_BITS-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.coarse_addr <= addr;
    in_ch.coarse_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model.note_item(m, addr, val);
    words_sent++;
    if (m == MODE_STEP) steps_sent++;
  endtask

  // Waits until every owed sample has arrived and the block has gone quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model.write_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_sizes(int fx, int fy, int fz, int cx, int cy, int cz);
    write_reg(REG_FINE_SIZE_X, CFG_DATA_BITS'(fx));
    write_reg(REG_FINE_SIZE_Y, CFG_DATA_BITS'(fy));
    write_reg(REG_FINE_SIZE_Z, CFG_DATA_BITS'(fz));
    write_reg(REG_COARSE_SIZE_X, CFG_DATA_BITS'(cx));
    write_reg(REG_COARSE_SIZE_Y, CFG_DATA_BITS'(cy));
    write_reg(REG_COARSE_SIZE_Z, CFG_DATA_BITS'(cz));
  endtask

  // Fills every coarse entry the current sizes can reach, so no step reads an unwritten one.
  task automatic fill_grid();
    int n;
    n = 1;
    foreach (model.coarse_sz[i])
      n *= model.coarse_sz[i] > COARSE_DIM_MAX_DEF ? COARSE_DIM_MAX_DEF : model.coarse_sz[i];
    for (int a = 0; a < n; a++)
      send_word(MODE_LOAD, CADDR_BITS'(a), CVAL_BITS'($urandom()));
  endtask

  // Steps through the fine grid with random loads mixed in.
  task automatic walk(int n, int load_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < load_pct)
        send_word(MODE_LOAD, CADDR_BITS'($urandom_range(STORE_WORDS - 1)),
                  CVAL_BITS'($urandom()));
      else
        send_word(MODE_STEP, CADDR_BITS'($urandom()), CVAL_BITS'($urandom()));
    end
  endtask

  initial begin
    logic [CVAL_BITS-1:0] corners[8];
    int phase;
    corners = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h000001,
                24'hFFFFFF, 24'h001000, 24'h7FF000, 24'h800001};
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.coarse_addr = '0;
    in_ch.coarse_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    hold_req = 1'b0;
    send_idle_pct = 30;
    recv_stall_pct = 59;
    model.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme corners at reset sizes, one full walk plus a wrap.
    for (int a = 0; a < 8; a++) send_word(MODE_LOAD, CADDR_BITS'(a), corners[a]);
    walk(9, 0);
    drain();
    // Bounds flag off, then a size below two, then an unknown register index.
    write_reg(REG_BOUNDS_OK, 0);
    walk(2, 0);
    drain();
    write_reg(REG_BOUNDS_OK, 1);
    write_reg(REG_FINE_SIZE_X, 0);
    walk(1, 0);
    drain();
    write_reg(REG_FINE_SIZE_X, 1);
    write_reg(REG_COARSE_SIZE_Z, 1);
    walk(1, 0);
    drain();
    write_reg(REG_UNUSED, 9'h1FF);
    // Oversized registers saturate to the maxima.
    set_sizes(9'h1FF, 2, 2, 9'h1FF, 2, 2);
    fill_grid();
    walk(4, 0);
    drain();

    // Random phases: mostly small grids, now and then the largest ones or a fine size below two.
    phase = 0;
    while (words_sent < 750) begin
      if (words_sent >= 500) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (words_sent >= 250) begin
        send_idle_pct = 59;
        recv_stall_pct = 30;
      end
      case ($urandom_range(9))
        0: set_sizes($urandom_range(200, 256), $urandom_range(2, 3), 2,
                     $urandom_range(28, 32), 2, 2);
        1: set_sizes(2, $urandom_range(2, 4), 256, 2, 2, 32);
        2: set_sizes($urandom_range(0, 1), 3, 3, 2, 3, 2);
        default: set_sizes($urandom_range(2, 9), $urandom_range(2, 9), $urandom_range(2, 6),
                           $urandom_range(2, 4), $urandom_range(2, 4), $urandom_range(2, 4));
      endcase
      fill_grid();
      if (phase == 3) begin
        // Long receiver hold-off while words keep coming.
        in_ch.valid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      walk($urandom_range(30, 60), 20);
      if ($urandom_range(4) == 0) begin
        drain();
        write_reg(REG_BOUNDS_OK, 0);
        walk(3, 0);
        drain();
        write_reg(REG_BOUNDS_OK, 1);
      end
      drain();
      phase++;
    end

    drain();
    $display("Sent %0d words (%0d steps), %0d register writes, %0d results checked.",
             words_sent, steps_sent, reg_writes, model.results_seen);
    $display("Statuses seen: ok %0d, bounds %0d, low resolution %0d; %0d mismatches.",
             model.status_seen[0], model.status_seen[1], model.status_seen[2], model.errors);
    if (model.errors == 0 && model.owed.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d samples still owed.", model.owed.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tgu_pkg.sv
rtl/core/tgu_in_if.sv
rtl/core/tgu_out_if.sv
rtl/core/tgu_cfg_if.sv
rtl/core/tgu_ram.sv
rtl/core/tgu_div.sv
rtl/core/tgu_blend.sv
rtl/core/trilinear_grid_upsampler_top.sv
sim/trilinear_grid_upsampler_top_test.sv
